// ===== design/ata_tf_pkg.sv =====
// ----------------------------------------------------------------------------
// ata_tf_pkg
// Shared types and constants for the taskfile command setup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ata_tf_pkg;

  // Taskfile register codes.
  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_SECCOUNT = 3'd1;
  localparam logic [2:0] REG_ADDR0    = 3'd2;
  localparam logic [2:0] REG_ADDR1    = 3'd3;
  localparam logic [2:0] REG_ADDR2    = 3'd4;
  localparam logic [2:0] REG_DEVSEL   = 3'd5;
  localparam logic [2:0] REG_COMMAND  = 3'd6;

  // Command bytes.
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

  localparam logic [7:0] CONTROL_NIEN = 8'h02;
  localparam logic [7:0] DEV_CHS      = 8'hA0;
  localparam logic [7:0] DEV_LBA      = 8'hE0;

  // Reciprocal of 63 scaled by 2^34, used for the CHS division.
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [28:0] RECIP_63    = 29'd272696336;
  localparam logic [7:0]  SECTS_PER_TRACK = 8'd63;

  // Beat positions within one run.
  localparam logic [3:0] BEAT_CTRL   = 4'd0;
  localparam logic [3:0] BEAT_DEV    = 4'd1;
  localparam logic [3:0] BEAT_HOB_SC = 4'd2;
  localparam logic [3:0] BEAT_HOB_A0 = 4'd3;
  localparam logic [3:0] BEAT_HOB_A1 = 4'd4;
  localparam logic [3:0] BEAT_HOB_A2 = 4'd5;
  localparam logic [3:0] BEAT_CNT    = 4'd6;
  localparam logic [3:0] BEAT_A0     = 4'd7;
  localparam logic [3:0] BEAT_A1     = 4'd8;
  localparam logic [3:0] BEAT_A2     = 4'd9;
  localparam logic [3:0] BEAT_CMD    = 4'd10;

  // Fully resolved run, handed from the address pipeline to the sequencer.
  typedef struct packed {
    logic       ext;
    logic [7:0] dev;
    logic [7:0] hob_a0;
    logic [7:0] cnt;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] cmd;
  } run_t;

endpackage

`default_nettype wire

// ===== design/ata_tf_addr.sv =====
// ----------------------------------------------------------------------------
// ata_tf_addr
// Three-stage pipeline that resolves the address mode and all run bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_tf_addr (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   write_dir,
  input  wire                   slave,
  input  wire                   lba_capable,
  input  wire  [31:0]           lba,
  input  wire  [7:0]            sector_count,
  output logic                  run_valid,
  input  wire                   run_ready,
  output ata_tf_pkg::run_t      run
);

  // Stage 1: operands and the reciprocal product's quotient estimate.
  logic        v1;
  logic        wr1, slv1, cap1;
  logic [31:0] lba1;
  logic [7:0]  cnt1;
  logic [21:0] q0;

  // Stage 2: corrected quotient and sector number.
  logic        v2;
  logic        wr2, slv2, cap2;
  logic [31:0] lba2;
  logic [7:0]  cnt2;
  logic [21:0] q;
  logic [5:0]  sect;

  logic        s1_ready, s2_ready, s3_ready;
  logic [56:0] prod;
  logic [7:0]  q63_lo;
  logic [7:0]  rem0;
  logic [7:0]  rem_fix;
  logic        ext2;
  logic [15:0] cyl;
  ata_tf_pkg::run_t run_next;

  assign s3_ready = !run_valid || run_ready;
  assign s2_ready = !v2 || s3_ready;
  assign s1_ready = !v1 || s2_ready;
  assign in_ready = s1_ready;

  assign prod = {1'b0, lba[27:0]} * {28'd0, ata_tf_pkg::RECIP_63};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= in_valid;
    end
    if (s1_ready && in_valid) begin
      wr1  <= write_dir;
      slv1 <= slave;
      cap1 <= lba_capable;
      lba1 <= lba;
      cnt1 <= sector_count;
      q0   <= prod[ata_tf_pkg::RECIP_SHIFT +: 22];
    end
  end

  // The estimate is exact or one short, so the remainder lies below 126
  // and its low byte is enough.
  assign q63_lo  = {q0[1:0], 6'd0} - q0[7:0];
  assign rem0    = lba1[7:0] - q63_lo;
  assign rem_fix = rem0 - ata_tf_pkg::SECTS_PER_TRACK;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_ready) begin
      v2 <= v1;
    end
    if (s2_ready && v1) begin
      wr2  <= wr1;
      slv2 <= slv1;
      cap2 <= cap1;
      lba2 <= lba1;
      cnt2 <= cnt1;
      if (rem0 >= ata_tf_pkg::SECTS_PER_TRACK) begin
        q    <= q0 + 22'd1;
        sect <= rem_fix[5:0] + 6'd1;
      end else begin
        q    <= q0;
        sect <= rem0[5:0] + 6'd1;
      end
    end
  end

  assign ext2 = (lba2[31:28] != 4'd0);
  assign cyl  = q[19:4];

  always_comb begin
    run_next.ext    = ext2;
    run_next.hob_a0 = lba2[31:24];
    run_next.cnt    = cnt2;
    if (ext2) begin
      run_next.a0  = lba2[7:0];
      run_next.a1  = lba2[15:8];
      run_next.a2  = lba2[23:16];
      run_next.dev = ata_tf_pkg::DEV_LBA | {3'd0, slv2, 4'd0};
      run_next.cmd = wr2 ? ata_tf_pkg::CMD_WRITE_EXT : ata_tf_pkg::CMD_READ_EXT;
    end else if (cap2) begin
      run_next.a0  = lba2[7:0];
      run_next.a1  = lba2[15:8];
      run_next.a2  = lba2[23:16];
      run_next.dev = ata_tf_pkg::DEV_LBA | {3'd0, slv2, lba2[27:24]};
      run_next.cmd = wr2 ? ata_tf_pkg::CMD_WRITE : ata_tf_pkg::CMD_READ;
    end else begin
      run_next.a0  = {2'd0, sect};
      run_next.a1  = cyl[7:0];
      run_next.a2  = cyl[15:8];
      run_next.dev = ata_tf_pkg::DEV_CHS | {3'd0, slv2, q[3:0]};
      run_next.cmd = wr2 ? ata_tf_pkg::CMD_WRITE : ata_tf_pkg::CMD_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (s3_ready) begin
      run_valid <= v2;
    end
    if (s3_ready && v2) begin
      run <= run_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ata_tf_seq.sv =====
// ----------------------------------------------------------------------------
// ata_tf_seq
// Holds one resolved run and plays it out as taskfile write beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_tf_seq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   run_valid,
  output logic                  run_ready,
  input  wire  ata_tf_pkg::run_t run,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [2:0]            reg_code,
  output logic                  high_order,
  output logic [7:0]            value,
  output logic                  last
);

  ata_tf_pkg::run_t held;
  logic [3:0]       beat;
  logic [3:0]       beat_next;
  logic             advance;
  logic             final_beat;

  assign advance    = out_valid && !out_stall;
  assign final_beat = (beat == ata_tf_pkg::BEAT_CMD);
  // A new run may load while the command beat of the previous one leaves.
  assign run_ready  = !out_valid || (advance && final_beat);

  always_comb begin
    if (beat == ata_tf_pkg::BEAT_DEV && !held.ext) begin
      beat_next = ata_tf_pkg::BEAT_CNT;
    end else begin
      beat_next = beat + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= ata_tf_pkg::BEAT_CTRL;
    end else if (run_ready) begin
      out_valid <= run_valid;
      beat      <= ata_tf_pkg::BEAT_CTRL;
    end else if (advance) begin
      beat <= beat_next;
    end
    if (run_ready && run_valid) begin
      held <= run;
    end
  end

  always_comb begin
    high_order = 1'b0;
    last       = 1'b0;
    case (beat)
      ata_tf_pkg::BEAT_CTRL: begin
        reg_code = ata_tf_pkg::REG_CONTROL;
        value    = ata_tf_pkg::CONTROL_NIEN;
      end
      ata_tf_pkg::BEAT_DEV: begin
        reg_code = ata_tf_pkg::REG_DEVSEL;
        value    = held.dev;
      end
      ata_tf_pkg::BEAT_HOB_SC: begin
        reg_code   = ata_tf_pkg::REG_SECCOUNT;
        value      = 8'd0;
        high_order = 1'b1;
      end
      ata_tf_pkg::BEAT_HOB_A0: begin
        reg_code   = ata_tf_pkg::REG_ADDR0;
        value      = held.hob_a0;
        high_order = 1'b1;
      end
      ata_tf_pkg::BEAT_HOB_A1: begin
        reg_code   = ata_tf_pkg::REG_ADDR1;
        value      = 8'd0;
        high_order = 1'b1;
      end
      ata_tf_pkg::BEAT_HOB_A2: begin
        reg_code   = ata_tf_pkg::REG_ADDR2;
        value      = 8'd0;
        high_order = 1'b1;
      end
      ata_tf_pkg::BEAT_CNT: begin
        reg_code = ata_tf_pkg::REG_SECCOUNT;
        value    = held.cnt;
      end
      ata_tf_pkg::BEAT_A0: begin
        reg_code = ata_tf_pkg::REG_ADDR0;
        value    = held.a0;
      end
      ata_tf_pkg::BEAT_A1: begin
        reg_code = ata_tf_pkg::REG_ADDR1;
        value    = held.a1;
      end
      ata_tf_pkg::BEAT_A2: begin
        reg_code = ata_tf_pkg::REG_ADDR2;
        value    = held.a2;
      end
      ata_tf_pkg::BEAT_CMD: begin
        reg_code = ata_tf_pkg::REG_COMMAND;
        value    = held.cmd;
        last     = 1'b1;
      end
      default: begin
        reg_code = ata_tf_pkg::REG_COMMAND;
        value    = held.cmd;
        last     = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ata_taskfile_command_setup_unit.sv =====
// ----------------------------------------------------------------------------
// ata_taskfile_command_setup_unit
// Turns one PIO sector request into the ordered run of taskfile writes.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on the input channel (in_valid, in_stall) carries the
// direction, drive, LBA support flag, 32-bit sector address and count.
// The output channel (out_valid, out_stall) then delivers one beat per
// register write: control, device select, four high-order writes when the
// address needs 48-bit mode, sector count, three address bytes and finally
// the command byte, which is flagged by last. A run is 11 beats in 48-bit
// mode and 7 beats otherwise.
// The request passes three register stages (reciprocal multiply for the
// cylinder/head/sector split, remainder correction, byte assembly) and
// then the sequencer register before the first beat of a run appears.
// The single write port sets the sustained rate: a run holds it for one
// beat per register write, with requests queued in the pipeline stages
// meanwhile and the next run following the command beat without a gap.
// Reset clears all valid bits; no beat is shown until a request arrives.
// While out_stall is high the current beat holds steady and the stages
// behind it fill up, after which in_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_taskfile_command_setup_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         write_dir,
  input  wire         slave,
  input  wire         lba_capable,
  input  wire  [31:0] lba,
  input  wire  [7:0]  sector_count,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  reg_code,
  output logic        high_order,
  output logic [7:0]  value,
  output logic        last
);

  logic             in_ready;
  logic             run_valid;
  logic             run_ready;
  ata_tf_pkg::run_t run;

  assign in_stall = !in_ready;

  // Address pipeline: resolves the mode and every byte of the run.
  ata_tf_addr u_addr (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .write_dir    (write_dir),
    .slave        (slave),
    .lba_capable  (lba_capable),
    .lba          (lba),
    .sector_count (sector_count),
    .run_valid    (run_valid),
    .run_ready    (run_ready),
    .run          (run)
  );

  // Sequencer: plays the held run out one register write per beat.
  ata_tf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .run_valid  (run_valid),
    .run_ready  (run_ready),
    .run        (run),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_code   (reg_code),
    .high_order (high_order),
    .value      (value),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== design/ata_tf_checker.sv =====
// ----------------------------------------------------------------------------
// ata_tf_checker
// Port-level checks on the beat stream of the command setup unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_tf_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_stall,
  input wire [2:0]  reg_code,
  input wire        high_order,
  input wire [7:0]  value,
  input wire        last
);

  // A stalled beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(out_valid && out_stall)) |->
      (out_valid && $stable(reg_code) && $stable(value) && $stable(last)))
    else $error("stalled beat changed");

  // Last marks the command write and nothing else.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (reg_code == ata_tf_pkg::REG_COMMAND)))
    else $error("last does not match the command write");

  // Device select follows the control write at once.
  a_devsel: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(out_valid && !out_stall &&
      reg_code == ata_tf_pkg::REG_CONTROL)) |->
      (out_valid && reg_code == ata_tf_pkg::REG_DEVSEL))
    else $error("device select did not follow control");

  // High-order writes only go to count and address registers.
  a_hob: assert property (@(posedge clk) disable iff (rst)
    (out_valid && high_order) |->
      (reg_code == ata_tf_pkg::REG_SECCOUNT || reg_code == ata_tf_pkg::REG_ADDR0 ||
       reg_code == ata_tf_pkg::REG_ADDR1 || reg_code == ata_tf_pkg::REG_ADDR2))
    else $error("high-order write to wrong register");

endmodule

bind ata_taskfile_command_setup_unit ata_tf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .reg_code   (reg_code),
  .high_order (high_order),
  .value      (value),
  .last       (last)
);

`default_nettype wire

// ===== dv/ata_taskfile_command_setup_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ata_taskfile_command_setup_unit_test
// Self-checking bench for the taskfile command setup unit.
// ----------------------------------------------------------------------------
// A queue of sector requests feeds a clocked driver that sends them in bursts
// with random gaps between them. Every accepted request is expanded by a
// predictor into the run of taskfile writes the unit ought to produce. A
// clocked monitor checks each accepted output beat against the oldest
// expected write, field by field. The receiver stalls in several patterns
// that change over the run, including stretches with no stalling at all.
// ----------------------------------------------------------------------------

module ata_taskfile_command_setup_unit_test;

  // Addresses at or above this need 48-bit addressing.
  localparam logic [31:0] LBA48_BASE   = 32'h1000_0000;
  localparam int unsigned CHS_HEADS    = 16;
  localparam int unsigned RANDOM_REQS  = 310;
  // Far beyond the slowest legal run: 329 requests of 11 beats each, with
  // long receiver stalls on every beat and the widest sender gaps.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  // Allow a good margin at the end, beyond the request-to-first-beat path.
  localparam int unsigned SETTLE_CYCLES = 24;

  // One sector request as it travels on the input channel. The drain flag
  // is bench-only: the driver holds this request back until every write
  // already expected has been seen.
  typedef struct packed {
    logic        drain_first;
    logic        write_dir;
    logic        slave;
    logic        lba_capable;
    logic [31:0] lba;
    logic [7:0]  sector_count;
  } sector_req_t;

  // One taskfile register write as seen on the output channel.
  typedef struct packed {
    logic [2:0] reg_code;
    logic       high_order;
    logic [7:0] value;
    logic       last;
  } taskfile_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        write_dir = 1'b0;
  logic        slave = 1'b0;
  logic        lba_capable = 1'b0;
  logic [31:0] lba = '0;
  logic [7:0]  sector_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  reg_code;
  logic        high_order;
  logic [7:0]  value;
  logic        last;

  ata_taskfile_command_setup_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .write_dir    (write_dir),
    .slave        (slave),
    .lba_capable  (lba_capable),
    .lba          (lba),
    .sector_count (sector_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reg_code     (reg_code),
    .high_order   (high_order),
    .value        (value),
    .last         (last)
  );

  // Requests waiting to be sent, and the writes still owed by the unit.
  sector_req_t     requests_to_send[$];
  taskfile_write_t writes_due[$];

  // writes_planned is advanced by the driver; writes_seen by the monitor
  // through a nonblocking update, so that the driver always reads a value
  // settled at the previous edge when it decides whether to hold back.
  int unsigned writes_planned = 0;
  int unsigned writes_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  // Requests taken by the unit so far, against the number queued in all.
  int unsigned reqs_accepted = 0;
  int unsigned reqs_total = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void owe_write(input logic [2:0] code, input logic hob,
                                    input logic [7:0] byte_val, input logic is_last);
    taskfile_write_t w;
    w.reg_code   = code;
    w.high_order = hob;
    w.value      = byte_val;
    w.last       = is_last;
    writes_due.push_back(w);
    writes_planned++;
  endfunction

  // Expands one accepted request into its run of register writes. The
  // address mode is chosen first: 48-bit for addresses from 2^28 upwards
  // whatever the drive reports, 28-bit when the drive supports LBA, and the
  // cylinder/head/sector split otherwise.
  function automatic void plan_taskfile_writes(input sector_req_t r);
    logic        ext;
    logic [31:0] track;
    logic [31:0] cyl;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [7:0]  dev;
    logic [7:0]  cmd;
    ext = (r.lba >= LBA48_BASE);
    if (ext) begin
      a0  = r.lba[7:0];
      a1  = r.lba[15:8];
      a2  = r.lba[23:16];
      dev = ata_tf_pkg::DEV_LBA | {3'b000, r.slave, 4'b0000};
      cmd = r.write_dir ? ata_tf_pkg::CMD_WRITE_EXT : ata_tf_pkg::CMD_READ_EXT;
    end else if (r.lba_capable) begin
      a0  = r.lba[7:0];
      a1  = r.lba[15:8];
      a2  = r.lba[23:16];
      dev = ata_tf_pkg::DEV_LBA | {3'b000, r.slave, r.lba[27:24]};
      cmd = r.write_dir ? ata_tf_pkg::CMD_WRITE : ata_tf_pkg::CMD_READ;
    end else begin
      // Sectors count from one; the cylinder wraps at 16 bits.
      track = r.lba / ata_tf_pkg::SECTS_PER_TRACK;
      a0    = 8'(r.lba % ata_tf_pkg::SECTS_PER_TRACK + 1);
      cyl   = (track / CHS_HEADS) & 32'h0000_FFFF;
      a1    = cyl[7:0];
      a2    = cyl[15:8];
      dev   = ata_tf_pkg::DEV_CHS | {3'b000, r.slave, 4'(track % CHS_HEADS)};
      cmd   = r.write_dir ? ata_tf_pkg::CMD_WRITE : ata_tf_pkg::CMD_READ;
    end
    owe_write(ata_tf_pkg::REG_CONTROL, 1'b0, ata_tf_pkg::CONTROL_NIEN, 1'b0);
    owe_write(ata_tf_pkg::REG_DEVSEL, 1'b0, dev, 1'b0);
    if (ext) begin
      // High-order bytes: only the top address byte carries anything.
      owe_write(ata_tf_pkg::REG_SECCOUNT, 1'b1, 8'h00, 1'b0);
      owe_write(ata_tf_pkg::REG_ADDR0, 1'b1, r.lba[31:24], 1'b0);
      owe_write(ata_tf_pkg::REG_ADDR1, 1'b1, 8'h00, 1'b0);
      owe_write(ata_tf_pkg::REG_ADDR2, 1'b1, 8'h00, 1'b0);
    end
    owe_write(ata_tf_pkg::REG_SECCOUNT, 1'b0, r.sector_count, 1'b0);
    owe_write(ata_tf_pkg::REG_ADDR0, 1'b0, a0, 1'b0);
    owe_write(ata_tf_pkg::REG_ADDR1, 1'b0, a1, 1'b0);
    owe_write(ata_tf_pkg::REG_ADDR2, 1'b0, a2, 1'b0);
    owe_write(ata_tf_pkg::REG_COMMAND, 1'b0, cmd, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of requests separated by random gaps.
  // --------------------------------------------------------------------------

  sector_req_t req_on_bus = '0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : request_driver
    logic present;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // The beat on the bus is taken at this edge: predict its writes.
      if (in_valid && !in_stall) begin
        plan_taskfile_writes(req_on_bus);
        reqs_accepted++;
      end
      if (!in_valid || !in_stall) begin
        present = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_to_send.size() != 0 &&
                     !(requests_to_send[0].drain_first &&
                       writes_seen != writes_planned)) begin
          req_on_bus = requests_to_send.pop_front();
          present = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Mostly short bursts and gaps, now and then a long unbroken
            // stretch or a long silence.
            case ($urandom_range(0, 7))
              0: begin
                burst_left = 40;
                gap_left   = 0;
              end
              1: begin
                burst_left = $urandom_range(1, 4);
                gap_left   = $urandom_range(10, 20);
              end
              default: begin
                burst_left = $urandom_range(1, 12);
                gap_left   = $urandom_range(0, 6);
              end
            endcase
          end
        end
        in_valid <= present;
        if (present) begin
          write_dir    <= req_on_bus.write_dir;
          slave        <= req_on_bus.slave;
          lba_capable  <= req_on_bus.lba_capable;
          lba          <= req_on_bus.lba;
          sector_count <= req_on_bus.sector_count;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern. The style changes every so often: no stalls,
  // scattered stalls, long stall runs, or a regular one-in-three pattern.
  // --------------------------------------------------------------------------

  int unsigned stall_style = 0;
  int unsigned stall_phase_left = 0;
  int unsigned stall_run = 0;

  always @(posedge clk) begin : receiver_stall
    logic hold;
    hold = 1'b0;
    if (stall_phase_left == 0) begin
      stall_style      = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(40, 300);
      stall_run        = 0;
    end else begin
      stall_phase_left--;
    end
    case (stall_style)
      1: hold = ($urandom_range(0, 99) < 35);
      2: begin
        if (stall_run > 0) begin
          stall_run--;
          hold = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_run = $urandom_range(2, 12);
          hold = 1'b1;
        end
      end
      3: hold = (stall_phase_left % 3 == 0);
      default: hold = 1'b0;
    endcase
    out_stall <= rst ? 1'b0 : hold;
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : write_monitor
    taskfile_write_t want;
    if (!rst && out_valid && !out_stall) begin
      writes_seen <= writes_seen + 1;
      if (writes_due.size() == 0) begin
        report_mismatch("beat with no write expected", 32'(value), 0);
      end else begin
        want = writes_due.pop_front();
        if (reg_code !== want.reg_code)
          report_mismatch("reg_code", 32'(reg_code), 32'(want.reg_code));
        if (high_order !== want.high_order)
          report_mismatch("high_order", 32'(high_order), 32'(want.high_order));
        if (value !== want.value)
          report_mismatch("value", 32'(value), 32'(want.value));
        if (last !== want.last)
          report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  // A generous ceiling on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ata_taskfile_command_setup_unit_test: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic sector_req_t make_req(input logic drain, input logic wr,
                                           input logic slv, input logic cap,
                                           input logic [31:0] addr,
                                           input logic [7:0] cnt);
    sector_req_t r;
    r.drain_first  = drain;
    r.write_dir    = wr;
    r.slave        = slv;
    r.lba_capable  = cap;
    r.lba          = addr;
    r.sector_count = cnt;
    return r;
  endfunction

  // Random requests lean on the three address modes in roughly equal
  // measure, with a share of small addresses for the sector and head
  // boundaries and a share of extreme counts.
  function automatic sector_req_t random_req(input logic drain);
    logic [31:0] addr;
    logic        cap;
    logic [7:0]  cnt;
    cap = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2: addr = $urandom_range(32'hFFFF_FFFF, LBA48_BASE);
      3, 4, 5: begin
        addr = $urandom_range(LBA48_BASE - 1, 0);
        cap  = 1'b1;
      end
      6, 7, 8: begin
        addr = $urandom_range(LBA48_BASE - 1, 0);
        cap  = 1'b0;
      end
      default: addr = $urandom_range(4095, 0);
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 8'h00;
      1: cnt = 8'hFF;
      default: cnt = 8'($urandom_range(0, 255));
    endcase
    return make_req(drain, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cap,
                    addr, cnt);
  endfunction

  initial begin
    // Directed part: every mode, both directions and drives, the mode
    // boundaries, sector and head roll-over, and cylinder wrap-around.
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 8'h00));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 8'hFF));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 8'h01));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_0000, 8'h80));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b0, 1'b0, 32'd62, 8'h10));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b0, 1'b0, 32'd63, 8'h10));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b1, 1'b0, 32'd1007, 8'h7F));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b1, 1'b0, 32'd1008, 8'h7F));
    // Last cylinder that fits in 16 bits, then the first that wraps.
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b0, 1'b0, 32'd66059280, 8'h02));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b1, 1'b0, 32'd66060288, 8'h03));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b0, 1'b0, 32'h0FFF_FFFF, 8'hFF));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h0FFF_FFFF, 8'h00));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b0, 1'b1, 32'h0ABC_DEF1, 8'h55));
    // 48-bit boundary and top; the LBA support flag must not matter here.
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b0, 1'b0, 32'h1000_0000, 8'h01));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b1, 1'b1, 32'h1000_0000, 8'hFE));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'hFF));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'h00));
    requests_to_send.push_back(make_req(1'b0, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 8'hAA));
    requests_to_send.push_back(make_req(1'b0, 1'b1, 1'b0, 1'b0, 32'h5A5A_A5A5, 8'h5A));

    // Random part. A few requests wait for the unit to drain completely
    // before they go out.
    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      requests_to_send.push_back(random_req(i % 100 == 0));
    end
    reqs_total = requests_to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every request taken and every write it owes seen.
    while (reqs_accepted != reqs_total || writes_seen != writes_planned) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && writes_due.size() == 0) begin
      $display("ata_taskfile_command_setup_unit_test: PASS");
    end else begin
      $display("ata_taskfile_command_setup_unit_test: FAIL");
    end
    $finish;
  end

endmodule
